/* design/bdr_pkg.sv */
// Shared types, codes and helper functions for the button debounce block.
package bdr_pkg;

    localparam int unsigned OBJ_W    = 8;
    localparam int unsigned SHIFT_W  = 8;
    localparam int unsigned SECS_W   = 7;
    localparam int unsigned PRE_W    = 6;
    localparam int unsigned CODE_W   = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 8;

    localparam logic [SECS_W-1:0] SECS_MAX      = 7'h7f;
    localparam logic [PRE_W-1:0]  PRE_LIMIT_RST = 6'd33;
    localparam logic [SHIFT_W-1:0] SHIFT_ALL_LO = 8'h00;
    localparam logic [SHIFT_W-1:0] SHIFT_ALL_HI = 8'hff;

    typedef enum logic [CODE_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_TOGGLE  = 3'd1,
        ACT_SEND0   = 3'd2,
        ACT_SEND1   = 3'd3,
        ACT_REPEAT0 = 3'd4,
        ACT_REPEAT1 = 3'd5
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FALLING_ACTION      = 3'd0,
        REG_RISING_ACTION       = 3'd1,
        REG_REPEAT_INTERVAL     = 3'd2,
        REG_TICK_PRESCALE_LIMIT = 3'd3,
        REG_TARGET_OBJECT       = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic value;
    } t_send;

    typedef struct packed {
        logic             edge_event;
        logic             edge_level;
        logic             edge_send_valid;
        logic             edge_send_value;
        logic             repeat_send_valid;
        logic             repeat_send_value;
        logic [OBJ_W-1:0] send_object;
    } t_result;

    // Send decision for an accepted edge.
    function automatic t_send edge_action(input logic [CODE_W-1:0] code, input logic obj_on);
        t_send s;
        s = '0;
        case (code)
            ACT_TOGGLE: begin
                s.valid = 1'b1;
                s.value = ~obj_on;
            end
            ACT_SEND0, ACT_REPEAT0: begin
                s.valid = 1'b1;
            end
            ACT_SEND1, ACT_REPEAT1: begin
                s.valid = 1'b1;
                s.value = 1'b1;
            end
            default: s = '0;
        endcase
        return s;
    endfunction

    // Only the repeating codes send on a cyclic repeat.
    function automatic t_send repeat_action(input logic [CODE_W-1:0] code);
        t_send s;
        s = '0;
        case (code)
            ACT_REPEAT0: s.valid = 1'b1;
            ACT_REPEAT1: begin
                s.valid = 1'b1;
                s.value = 1'b1;
            end
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

/* design/bdr_if.sv */
// Handshake channel interfaces for poll samples, results and register writes.
interface bdr_in_if;
    logic                      valid;
    logic                      ready;
    logic                      pin_level;
    logic [bdr_pkg::OBJ_W-1:0] object_value;

    modport source (output valid, output pin_level, output object_value, input ready);
    modport sink   (input valid, input pin_level, input object_value, output ready);
endinterface

interface bdr_out_if;
    logic                      valid;
    logic                      ready;
    logic                      edge_event;
    logic                      edge_level;
    logic                      edge_send_valid;
    logic                      edge_send_value;
    logic                      repeat_send_valid;
    logic                      repeat_send_value;
    logic [bdr_pkg::OBJ_W-1:0] send_object;

    modport source (output valid, output edge_event, output edge_level,
                    output edge_send_valid, output edge_send_value,
                    output repeat_send_valid, output repeat_send_value,
                    output send_object, input ready);
    modport sink   (input valid, input edge_event, input edge_level,
                    input edge_send_valid, input edge_send_value,
                    input repeat_send_valid, input repeat_send_value,
                    input send_object, output ready);
endinterface

interface bdr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bdr_pkg::CFG_IDX_W-1:0] index;
    logic [bdr_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/button_debounce_edge_repeat_core.sv */
// Top level: debounced button with edge actions and cyclic repeat.
// Each input transaction is one poll tick (raw pin level plus the current target
// object value) and yields exactly one result transaction. The pin passes an
// 8-sample shift filter; the debounced level flips only when all eight samples
// agree. An edge clears the seconds counter and runs the action code for that
// edge; a prescaler of tick_prescale_limit+1 ticks advances the seconds counter,
// and when it reaches repeat_interval the repeat code for the present level is
// sent again. One tick is accepted every clock cycle unless the output stalls:
// the whole update sits in one level of logic ahead of a single result register,
// and a tick is taken whenever that register is empty or is being drained in the
// same cycle. Register writes are always ready and are only to be issued while
// no tick is in flight. Reset level is low, prescale limit 33.
module button_debounce_edge_repeat_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdr_in_if.sink    i_in,
    bdr_out_if.source o_out,
    bdr_cfg_if.sink   i_cfg
);
    import bdr_pkg::*;

    // configuration
    logic [CODE_W-1:0] r_falling_action;
    logic [CODE_W-1:0] r_rising_action;
    logic [SECS_W-1:0] r_repeat_interval;
    logic [PRE_W-1:0]  r_prescale_limit;
    logic [OBJ_W-1:0]  r_target_object;

    // running state
    logic [SHIFT_W-1:0] r_shift,  n_shift;
    logic               r_level,  n_level;
    logic [SECS_W-1:0]  r_secs,   n_secs;
    logic [PRE_W-1:0]   r_pre,    n_pre;

    // result register
    logic    r_out_valid;
    t_result r_out, n_out;

    logic              in_accept;
    logic              fall, rise, edge_ev;
    logic [CODE_W-1:0] edge_code, rep_code;
    t_send             edge_snd, rep_snd;
    logic [PRE_W:0]    pre_inc;
    logic              sec_tick;
    logic [SECS_W-1:0] secs_base, secs_inc;
    logic              rep_hit;

    assign i_in.ready  = ~r_out_valid | o_out.ready;
    assign in_accept   = i_in.valid & i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_shift = {i_in.pin_level, r_shift[SHIFT_W-1:1]};
        fall    = (n_shift == SHIFT_ALL_LO) & r_level;
        rise    = (n_shift == SHIFT_ALL_HI) & ~r_level;
        edge_ev = fall | rise;
        n_level = rise | (r_level & ~fall);

        edge_code = rise ? r_rising_action : r_falling_action;
        edge_snd  = edge_ev ? edge_action(edge_code, |i_in.object_value) : '0;

        // edge restarts the seconds count before this tick's second is counted
        secs_base = edge_ev ? '0 : r_secs;
        pre_inc   = {1'b0, r_pre} + 1'b1;
        sec_tick  = pre_inc > {1'b0, r_prescale_limit};
        secs_inc  = (secs_base < SECS_MAX) ? secs_base + 1'b1 : secs_base;
        rep_hit   = sec_tick & (secs_inc == r_repeat_interval);

        n_pre  = sec_tick ? '0 : pre_inc[PRE_W-1:0];
        n_secs = !sec_tick ? secs_base : (rep_hit ? '0 : secs_inc);

        rep_code = n_level ? r_rising_action : r_falling_action;
        rep_snd  = rep_hit ? repeat_action(rep_code) : '0;

        n_out.edge_event        = edge_ev;
        n_out.edge_level        = rise;
        n_out.edge_send_valid   = edge_snd.valid;
        n_out.edge_send_value   = edge_snd.value;
        n_out.repeat_send_valid = rep_snd.valid;
        n_out.repeat_send_value = rep_snd.value;
        n_out.send_object       = r_target_object;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_falling_action  <= ACT_NONE;
            r_rising_action   <= ACT_NONE;
            r_repeat_interval <= '0;
            r_prescale_limit  <= PRE_LIMIT_RST;
            r_target_object   <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                REG_FALLING_ACTION:      r_falling_action  <= i_cfg.data[CODE_W-1:0];
                REG_RISING_ACTION:       r_rising_action   <= i_cfg.data[CODE_W-1:0];
                REG_REPEAT_INTERVAL:     r_repeat_interval <= i_cfg.data[SECS_W-1:0];
                REG_TICK_PRESCALE_LIMIT: r_prescale_limit  <= i_cfg.data[PRE_W-1:0];
                REG_TARGET_OBJECT:       r_target_object   <= i_cfg.data[OBJ_W-1:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_level     <= 1'b0;
            r_secs      <= '0;
            r_pre       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_shift <= n_shift;
                r_level <= n_level;
                r_secs  <= n_secs;
                r_pre   <= n_pre;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.edge_event        = r_out.edge_event;
    assign o_out.edge_level        = r_out.edge_level;
    assign o_out.edge_send_valid   = r_out.edge_send_valid;
    assign o_out.edge_send_value   = r_out.edge_send_value;
    assign o_out.repeat_send_valid = r_out.repeat_send_valid;
    assign o_out.repeat_send_value = r_out.repeat_send_value;
    assign o_out.send_object       = r_out.send_object;

endmodule
